/* rtl/owpw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owpw_pkg
// Shared types and constants of the one-wire pulse-width command transmitter.
// ----------------------------------------------------------------------------
package owpw_pkg;

   localparam int CMD_BITS_DEF = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MUTE_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_TICKS = 2'd1;

   localparam logic [15:0] UNIT_TICKS_RST = 16'd500;

   typedef struct packed {
      logic       action;
      logic [7:0] cmd_code;
      logic       busy_in;
   } req_type;

   typedef struct packed {
      logic data_line;
      logic idle;
      logic req_rejected;
   } rsp_type;

   typedef struct packed {
      logic        mute_mode;
      logic [15:0] unit_ticks;
   } cfg_type;

endpackage

/* rtl/owpw_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owpw_seq
// Transfer sequencer: request latch, busy wait, sync header and bit cells.
// Advances one tick per accepted request and presents that tick's result.
// ----------------------------------------------------------------------------
module owpw_seq #(
   parameter int CMD_BITS = owpw_pkg::CMD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  owpw_pkg::req_type req,
   input  owpw_pkg::cfg_type cfg,
   output owpw_pkg::rsp_type rsp
);
   import owpw_pkg::*;

   localparam int BW = $clog2(CMD_BITS + 1);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_WAIT    = 3'd1;
   localparam logic [2:0] PH_SYNC_HI = 3'd2;
   localparam logic [2:0] PH_SYNC_LO = 3'd3;
   localparam logic [2:0] PH_BIT_HI  = 3'd4;
   localparam logic [2:0] PH_BIT_LO  = 3'd5;

   localparam logic [4:0] SYNC_HI_UNITS = 5'd16;
   localparam logic [4:0] SYNC_LO_UNITS = 5'd2;
   localparam logic [4:0] LONG_UNITS    = 5'd3;
   localparam logic [4:0] SHORT_UNITS   = 5'd1;

   logic [2:0]          phase_ff, phase_in;
   logic [CMD_BITS-1:0] shift_ff, shift_in;
   logic [BW-1:0]       bits_ff, bits_in;
   logic [15:0]         tick_ff, tick_in;
   logic [4:0]          unit_ff, unit_in;
   logic                line_ff, line_in;

   logic [15:0] limit;
   logic [4:0]  seg_units;
   logic [BW-1:0] bits_dec;
   logic        rejected;
   logic        level;

   assign limit = (cfg.unit_ticks == 16'd0) ? 16'd1 : cfg.unit_ticks;

   always_comb begin
      phase_in  = phase_ff;
      shift_in  = shift_ff;
      bits_in   = bits_ff;
      tick_in   = tick_ff;
      unit_in   = unit_ff;
      line_in   = line_ff;
      rejected  = 1'b0;
      seg_units = SHORT_UNITS;
      bits_dec  = bits_ff;

      // new request
      if (req.action) begin
         if (phase_ff == PH_IDLE) begin
            if (!cfg.mute_mode) begin
               shift_in = CMD_BITS'(req.cmd_code);
               bits_in  = BW'(CMD_BITS);
               phase_in = PH_WAIT;
               line_in  = 1'b0;
               tick_in  = 16'd0;
               unit_in  = 5'd0;
            end
         end else begin
            rejected = 1'b1;
         end
      end

      if (phase_in == PH_WAIT && !req.busy_in) begin
         phase_in = PH_SYNC_HI;
         line_in  = 1'b1;
         tick_in  = 16'd0;
         unit_in  = 5'd0;
      end

      level = line_in;

      unique case (phase_in)
         PH_SYNC_HI: seg_units = SYNC_HI_UNITS;
         PH_SYNC_LO: seg_units = SYNC_LO_UNITS;
         PH_BIT_HI:  seg_units = shift_in[CMD_BITS-1] ? LONG_UNITS : SHORT_UNITS;
         PH_BIT_LO:  seg_units = shift_in[CMD_BITS-1] ? SHORT_UNITS : LONG_UNITS;
         default:    seg_units = SHORT_UNITS;
      endcase

      if (phase_in >= PH_SYNC_HI && phase_in <= PH_BIT_LO) begin
         tick_in = tick_in + 16'd1;
         if (tick_in >= limit) begin
            tick_in = 16'd0;
            unit_in = unit_in + 5'd1;
            if (unit_in >= seg_units) begin
               tick_in = 16'd0;
               unit_in = 5'd0;
               unique case (phase_in)
                  PH_SYNC_HI: begin
                     phase_in = PH_SYNC_LO;
                     line_in  = 1'b0;
                  end
                  PH_SYNC_LO: begin
                     phase_in = PH_BIT_HI;
                     line_in  = 1'b1;
                  end
                  PH_BIT_HI: begin
                     phase_in = PH_BIT_LO;
                     line_in  = 1'b0;
                  end
                  default: begin
                     shift_in = shift_in << 1;
                     bits_dec = (bits_in != '0) ? bits_in - BW'(1) : '0;
                     bits_in  = bits_dec;
                     if (bits_dec != '0) begin
                        phase_in = PH_BIT_HI;
                        line_in  = 1'b1;
                     end else begin
                        phase_in = PH_IDLE;
                        line_in  = 1'b0;
                     end
                  end
               endcase
            end
         end
      end

      rsp.data_line    = level;
      rsp.idle         = (phase_in == PH_IDLE);
      rsp.req_rejected = rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         shift_ff <= '0;
         bits_ff  <= '0;
         tick_ff  <= 16'd0;
         unit_ff  <= 5'd0;
         line_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         tick_ff  <= tick_in;
         unit_ff  <= unit_in;
         line_ff  <= line_in;
      end
   end

endmodule

/* rtl/one_wire_pulse_width_cmd_tx_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_pulse_width_cmd_tx_unit
// Sends a command byte to a sound module as high/low pulse widths on one line.
// ----------------------------------------------------------------------------
// Each request is one tick of the timing base and yields exactly one response
// in the cycle after it is accepted, from an output register. A new request is taken every
// cycle while the response register is empty or being drained, so the block
// sustains one request per cycle; only rsp_ready backpressure stalls it.
// A play request taken while idle and not muted waits for busy_in low, then
// sends a 16-unit high / 2-unit low header and CMD_BITS data bits MSB first
// (one: 3 high, 1 low; zero: 1 high, 3 low), one unit being unit_ticks ticks (zero counts as one).
// Configuration writes complete in the cycle they are presented.
// ----------------------------------------------------------------------------
module one_wire_pulse_width_cmd_tx_unit #(
   parameter int CMD_BITS = owpw_pkg::CMD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  owpw_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output owpw_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [owpw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [owpw_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import owpw_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_next;
   logic    accept;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MUTE_MODE:  cfg_in.mute_mode  = csr_wdata[0];
            CSR_UNIT_TICKS: cfg_in.unit_ticks = csr_wdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   owpw_seq #(
      .CMD_BITS(CMD_BITS)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .step (accept),
      .req  (req_data),
      .cfg  (cfg_ff),
      .rsp  (rsp_next)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mute_mode  <= 1'b0;
         cfg_ff.unit_ticks <= UNIT_TICKS_RST;
         rsp_valid_ff      <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/sv/tb_one_wire_pulse_width_cmd_tx_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_wire_pulse_width_cmd_tx_unit
// Self-checking testbench for the one-wire pulse-width command transmitter.
// ----------------------------------------------------------------------------
// Every accepted request is one tick of the timing base. A line tracker keeps
// its own copy of the transfer state and the registers, works out the line
// level, idle and reject flags for each request, and compares them with the
// responses in order. A short directed part covers muted requests, the wait
// on busy, rejects during a transfer and unit length changes mid-unit; then
// random phases under several register settings run complete transfers with
// random command bytes and busy levels. Both handshakes see random gaps.
// ----------------------------------------------------------------------------
module tb_one_wire_pulse_width_cmd_tx_unit;
   import owpw_pkg::*;

   localparam int CMD_W           = CMD_BITS_DEF;
   localparam int SYNC_HIGH_UNITS = 16;
   localparam int SYNC_LOW_UNITS  = 2;
   localparam int LONG_UNITS      = 3;
   localparam int SHORT_UNITS     = 1;
   localparam int RANDOM_PHASES   = 5;
   localparam int PHASE_REQS      = 100;

   typedef enum logic [2:0] {
      TX_IDLE, TX_WAIT_BUSY, TX_SYNC_HIGH, TX_SYNC_LOW, TX_BIT_HIGH, TX_BIT_LOW
   } tx_phase_e;

   class tx_line_checker;
      bit              mute;
      logic [15:0]     unit_ticks;
      tx_phase_e       phase;
      logic [CMD_W-1:0] shift_cmd;
      logic [4:0]      bits_left;
      logic [15:0]     tick_count;
      logic [4:0]      unit_count;
      logic            line_level;
      rsp_type         expected_rsp[$];
      int              errors;

      function new();
         mute       = 1'b0;
         unit_ticks = UNIT_TICKS_RST;
         phase      = TX_IDLE;
         shift_cmd  = '0;
         bits_left  = '0;
         tick_count = '0;
         unit_count = '0;
         line_level = 1'b0;
         errors     = 0;
      endfunction

      function void enter_segment(tx_phase_e ph, logic level);
         phase      = ph;
         line_level = level;
         tick_count = '0;
         unit_count = '0;
      endfunction

      function int segment_units();
         case (phase)
            TX_SYNC_HIGH: return SYNC_HIGH_UNITS;
            TX_SYNC_LOW:  return SYNC_LOW_UNITS;
            TX_BIT_HIGH:  return shift_cmd[CMD_W-1] ? LONG_UNITS : SHORT_UNITS;
            TX_BIT_LOW:   return shift_cmd[CMD_W-1] ? SHORT_UNITS : LONG_UNITS;
            default:      return 1;
         endcase
      endfunction

      function void next_segment();
         case (phase)
            TX_SYNC_HIGH: enter_segment(TX_SYNC_LOW, 1'b0);
            TX_SYNC_LOW:  enter_segment(TX_BIT_HIGH, 1'b1);
            TX_BIT_HIGH:  enter_segment(TX_BIT_LOW, 1'b0);
            default: begin
               shift_cmd = shift_cmd << 1;
               if (bits_left > 0) bits_left = bits_left - 5'd1;
               if (bits_left > 0) enter_segment(TX_BIT_HIGH, 1'b1);
               else enter_segment(TX_IDLE, 1'b0);
            end
         endcase
      endfunction

      function rsp_type predict_tick(req_type r);
         rsp_type     res;
         logic [15:0] limit;
         res   = '0;
         limit = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;
         if (r.action) begin
            if (phase == TX_IDLE) begin
               if (!mute) begin
                  shift_cmd = CMD_W'(r.cmd_code);
                  bits_left = 5'(CMD_W);
                  enter_segment(TX_WAIT_BUSY, 1'b0);
               end
            end else begin
               res.req_rejected = 1'b1;
            end
         end
         if (phase == TX_WAIT_BUSY && !r.busy_in) enter_segment(TX_SYNC_HIGH, 1'b1);
         res.data_line = line_level;
         if (phase >= TX_SYNC_HIGH && phase <= TX_BIT_LOW) begin
            tick_count = tick_count + 16'd1;
            if (tick_count >= limit) begin
               tick_count = '0;
               unit_count = unit_count + 5'd1;
               if (unit_count >= segment_units()) next_segment();
            end
         end
         res.idle = (phase == TX_IDLE);
         return res;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_MUTE_MODE:  mute = data[0];
            CSR_UNIT_TICKS: unit_ticks = data;
            default: ;
         endcase
      endfunction

      function void note_request(req_type r);
         expected_rsp.push_back(predict_tick(r));
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      task report_mismatch(string msg);
         $display("ERROR @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("response %b with no request pending", got));
         end else begin
            want = expected_rsp.pop_front();
            if (got.data_line !== want.data_line)
               report_mismatch($sformatf("data_line %b, want %b", got.data_line,
                                         want.data_line));
            if (got.idle !== want.idle)
               report_mismatch($sformatf("idle %b, want %b", got.idle, want.idle));
            if (got.req_rejected !== want.req_rejected)
               report_mismatch($sformatf("req_rejected %b, want %b", got.req_rejected,
                                         want.req_rejected));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tx_line_checker line_chk;
   logic           busy_level;
   int             rsp_hold;
   int             rsp_stall;

   one_wire_pulse_width_cmd_tx_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   // response side: ready stretches alternate with stalls
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (!rsp_ready) begin
         rsp_ready <= 1'b1;
         rsp_hold  <= $urandom_range(0, 30);
      end else begin
         rsp_stall  = pick_gap();
         rsp_hold  <= rsp_stall;
         rsp_ready <= (rsp_stall == 0) ? 1'b1 : 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) line_chk.check_response(rsp_data);
         if (req_valid && req_ready) line_chk.note_request(req_data);
         if (csr_valid && csr_ready) line_chk.write_reg(csr_index, csr_wdata);
      end
   end

   task automatic send_req(logic act, logic [7:0] cmd, logic busy);
      int gap;
      req_type r;
      gap        = pick_gap();
      r.action   = act;
      r.cmd_code = cmd;
      r.busy_in  = busy;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random_req();
      if ($urandom_range(0, 11) == 0) busy_level = ~busy_level;
      send_req($urandom_range(0, 5) == 0, 8'($urandom), busy_level);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      @(posedge clock);
      while (line_chk.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic              phase_mute [RANDOM_PHASES];
      logic [15:0]       phase_ticks[RANDOM_PHASES];
      line_chk   = new();
      busy_level = 1'b0;
      rsp_hold   = 0;
      phase_mute  = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
      phase_ticks = '{16'd1, 16'd2, 16'd1, 16'd3, 16'd1};
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_ready <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_MUTE_MODE;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // muted while idle: requests dropped silently
      write_csr(CSR_MUTE_MODE, 16'd1);
      send_req(1'b1, 8'hA5, 1'b0);
      send_req(1'b1, 8'h5A, 1'b1);

      // wait on busy, reject while waiting, busy ignored once sending
      write_csr(CSR_MUTE_MODE, 16'd0);
      send_req(1'b1, 8'hFF, 1'b1);
      send_req(1'b0, 8'h00, 1'b1);
      send_req(1'b1, 8'h00, 1'b0);
      send_req(1'b0, 8'h00, 1'b1);
      send_req(1'b1, 8'h81, 1'b1);

      // longest unit, then zero unit length ends the running unit at once
      write_csr(CSR_UNIT_TICKS, 16'hFFFF);
      repeat (6) send_req(1'b0, 8'($urandom), 1'($urandom));
      write_csr(CSR_UNIT_TICKS, 16'h0000);
      repeat (8) send_req(1'b0, 8'($urandom), 1'($urandom));

      // mute during a transfer: the request is rejected and the transfer goes on
      write_csr(CSR_MUTE_MODE, 16'd1);
      send_req(1'b1, 8'h3C, 1'b0);
      send_req(1'b0, 8'h00, 1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_csr(CSR_MUTE_MODE, 16'(phase_mute[p]));
         write_csr(CSR_UNIT_TICKS, phase_ticks[p]);
         repeat (PHASE_REQS) send_random_req();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (line_chk.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (line_chk.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
